>>> sv/multi_led_blink_controller_macros.svh
// assertion macros for the blink controller sequencer
`ifndef MULTI_LED_BLINK_CONTROLLER_MACROS_SVH
`define MULTI_LED_BLINK_CONTROLLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MLBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define MLBC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define MLBC_ASSERT(lbl, prop, msg)
`define MLBC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> sv/mlbc_pkg.sv
package mlbc_pkg;

	localparam int LED_COUNT_DEF = 8;

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_BLINK = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [7:0] PRESET_COUNT  = 8'hFE;
	localparam logic [7:0] ENDLESS_LIMIT = 8'd100;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] led_index;
		logic [7:0] blink_count;
		logic [7:0] high_time;
		logic [7:0] low_time;
	} item_t;

	typedef struct packed {
		logic [7:0] led_states;
		logic [7:0] finish_mask;
	} result_t;

	// sequencer to datapath
	typedef struct packed {
		logic load_item;
		logic exec_blink;
		logic exec_clear;
		logic rd_en;
		logic upd_en;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to sequencer
	typedef struct packed {
		logic [1:0] kind;
	} dp_status_t;

endpackage

>>> sv/mlbc_stream_if.sv
interface mlbc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/mlbc_datapath.sv
module mlbc_datapath import mlbc_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF,
	localparam int IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  item_t           item_data,
	input  ctrl_cmd_t       cmd,
	input  logic [IdxW-1:0] rd_idx,
	input  logic [IdxW-1:0] upd_idx,
	output dp_status_t      status,
	output result_t         result_data
);

	item_t       item_q;
	result_t     res_q;
	logic        lit_q [LED_COUNT];
	logic [7:0]  cnt_q [LED_COUNT];
	logic [7:0]  tl_q  [LED_COUNT];
	logic        en_q  [LED_COUNT];
	logic [15:0] time_mem [LED_COUNT];
	logic [15:0] times_s1;
	logic [7:0]  finish_q;

	logic            in_range;
	logic            blink_wr;
	logic [IdxW-1:0] widx;
	logic            cur_lit;
	logic [7:0]      cur_cnt;
	logic [7:0]      cur_tl;
	logic            cur_en;
	logic            cur_active;
	logic [7:0]      lim;
	logic [7:0]      cnt_inc;
	logic [7:0]      tl_dec;
	logic            over;
	logic            fin_now;
	logic [7:0]      lit_view;
	logic [7:0]      fin_hit;

	assign status.kind = item_q.kind;
	assign result_data = res_q;

	assign in_range = int'(item_q.led_index) < LED_COUNT;
	assign blink_wr = cmd.exec_blink && in_range;
	assign widx     = IdxW'(item_q.led_index);

	// per-led step for the entry under the scan
	assign cur_lit    = lit_q[upd_idx];
	assign cur_cnt    = cnt_q[upd_idx];
	assign cur_tl     = tl_q[upd_idx];
	assign cur_en     = en_q[upd_idx];
	assign cur_active = (cur_tl != 8'd0) || cur_en;
	assign lim        = cur_lit ? times_s1[15:8] : times_s1[7:0];
	assign cnt_inc    = cur_cnt + 8'd1;
	assign tl_dec     = cur_tl - 8'd1;
	assign over       = cnt_inc > lim;
	assign fin_now    = cmd.upd_en && cur_active && over && !cur_en && (tl_dec == 8'd0);

	for (genvar j = 0; j < 8; j++) begin : g_view
		if (j < LED_COUNT) begin : g_on
			assign lit_view[j] = lit_q[j];
			assign fin_hit[j]  = (upd_idx == IdxW'(j));
		end else begin : g_off
			assign lit_view[j] = 1'b0;
			assign fin_hit[j]  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item_data;
		end
		if (cmd.load_out) begin
			res_q.led_states  <= lit_view;
			res_q.finish_mask <= finish_q;
		end
		if (cmd.load_item) begin
			finish_q <= 8'd0;
		end else if (fin_now) begin
			finish_q <= finish_q | fin_hit;
		end
	end

	// time store, undefined until a blink command writes it
	always_ff @(posedge clk) begin
		if (blink_wr) begin
			time_mem[widx] <= {item_q.high_time, item_q.low_time};
		end
		if (cmd.rd_en) begin
			times_s1 <= time_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				lit_q[i] <= 1'b0;
				cnt_q[i] <= 8'd0;
				tl_q[i]  <= 8'd0;
				en_q[i]  <= 1'b0;
			end
		end else if (cmd.exec_clear) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				lit_q[i] <= 1'b0;
				cnt_q[i] <= 8'd0;
				tl_q[i]  <= 8'd0;
				en_q[i]  <= 1'b0;
			end
		end else if (blink_wr) begin
			lit_q[widx] <= 1'b0;
			cnt_q[widx] <= PRESET_COUNT;
			if (item_q.blink_count > ENDLESS_LIMIT) begin
				en_q[widx] <= 1'b1;
				tl_q[widx] <= 8'd0;
			end else begin
				en_q[widx] <= 1'b0;
				tl_q[widx] <= {item_q.blink_count[6:0], 1'b0};
			end
		end else if (cmd.upd_en && cur_active) begin
			if (over) begin
				cnt_q[upd_idx] <= 8'd1;
				lit_q[upd_idx] <= !cur_lit;
				if (!cur_en) begin
					tl_q[upd_idx] <= tl_dec;
				end
			end else begin
				cnt_q[upd_idx] <= cnt_inc;
			end
		end
	end

endmodule

>>> sv/mlbc_ctrl.sv
`include "multi_led_blink_controller_macros.svh"

module mlbc_ctrl import mlbc_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF,
	localparam int IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  logic            result_ready,
	input  dp_status_t      status,
	output ctrl_cmd_t       cmd,
	output logic [IdxW-1:0] rd_idx,
	output logic [IdxW-1:0] upd_idx
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_POST = 2'd3;

	logic [1:0]      state_q;
	logic [IdxW-1:0] rd_idx_q;
	logic            rd_pend_q;
	logic            upd_vld_s1;
	logic [IdxW-1:0] upd_idx_s1;
	logic            out_vld_q;
	logic            accept;
	logic            out_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign out_free     = !out_vld_q || result_ready;
	assign result_valid = out_vld_q;
	assign rd_idx       = rd_idx_q;
	assign upd_idx      = upd_idx_s1;

	always_comb begin
		cmd = '0;
		cmd.load_item = accept;
		case (state_q)
			ST_EXEC: begin
				cmd.exec_blink = (status.kind == KIND_BLINK);
				cmd.exec_clear = (status.kind == KIND_CLEAR);
			end
			ST_SCAN: begin
				cmd.rd_en  = rd_pend_q;
				cmd.upd_en = upd_vld_s1;
			end
			ST_POST: begin
				cmd.load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			upd_idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_idx_q   <= '0;
			rd_pend_q  <= 1'b0;
			upd_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (status.kind == KIND_TICK) begin
						rd_idx_q   <= '0;
						rd_pend_q  <= 1'b1;
						upd_vld_s1 <= 1'b0;
						state_q    <= ST_SCAN;
					end else begin
						state_q <= ST_POST;
					end
				end
				ST_SCAN: begin
					upd_vld_s1 <= rd_pend_q;
					if (rd_pend_q) begin
						if (rd_idx_q == IdxW'(LED_COUNT - 1)) begin
							rd_pend_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (!rd_pend_q && upd_vld_s1) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MLBC_ASSERT(a_scan_drains, (state_q == ST_SCAN && !rd_pend_q) |-> upd_vld_s1, "scan stalled with nothing in flight")
	`MLBC_ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC, "accepted word not executed")
	`MLBC_ASSERT_NEXT(a_cmd_post, state_q == ST_EXEC && status.kind != KIND_TICK, state_q == ST_POST, "non-tick word did not finish at once")

endmodule

>>> sv/multi_led_blink_controller.sv
// tick word: the led scan steps through one led entry per cycle, then the result word is loaded
// other words: the command runs in the exec state, then the result word is loaded in the post state
// a new word is taken only in the idle state, once the previous word's result has gone into the output register
// the led scan does one time-store read per cycle, pipelined one deep
// reset clears every led (off, inactive, counters zero); stored times stay undefined until written
module multi_led_blink_controller import mlbc_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	mlbc_stream_if.sink            item,
	mlbc_stream_if.source          result
);

	localparam int IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	// command and status between sequencer and datapath
	ctrl_cmd_t       cmd;
	dp_status_t      status;
	logic [IdxW-1:0] rd_idx;
	logic [IdxW-1:0] upd_idx;

	// sequencer: takes a word, runs the command or the led scan, then parks
	// the result in the output register; a new word may be taken while the
	// previous result word still waits there
	mlbc_ctrl #(
		.LED_COUNT (LED_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd),
		.rd_idx       (rd_idx),
		.upd_idx      (upd_idx)
	);

	// datapath: per-led state, time store and the output word register
	mlbc_datapath #(
		.LED_COUNT (LED_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_data   (item.data),
		.cmd         (cmd),
		.rd_idx      (rd_idx),
		.upd_idx     (upd_idx),
		.status      (status),
		.result_data (result.data)
	);

endmodule
